// File: hw/rtl/ps2_mouse_packet_tracker_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the PS/2 mouse packet tracker checker
// ----------------------------------------------------------------------------
`ifndef PS2_MOUSE_PACKET_TRACKER_TOP_ASSERT_SVH
`define PS2_MOUSE_PACKET_TRACKER_TOP_ASSERT_SVH

// checked outside reset
`define PS2MT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define PS2MT_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: hw/rtl/ps2mt_pkg.sv
// ----------------------------------------------------------------------------
// ps2mt_pkg
// Shared types, codes and helpers of the PS/2 mouse packet tracker.
// ----------------------------------------------------------------------------
package ps2mt_pkg;

   localparam int COORD_BITS_DEF = 12;
   localparam int SIZE_BITS      = 13;
   localparam int CSR_INDEX_BITS = 1;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_SCREEN_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SCREEN_HEIGHT = 1'b1;

   // request kinds
   localparam logic REQ_DATA    = 1'b0;
   localparam logic REQ_CONSUME = 1'b1;

   localparam logic [SIZE_BITS-1:0] RESET_WIDTH  = 13'd1920;
   localparam logic [SIZE_BITS-1:0] RESET_HEIGHT = 13'd1080;
   localparam int RESET_X = 960;
   localparam int RESET_Y = 540;

   // header byte bit positions
   localparam int HDR_LEFT   = 0;
   localparam int HDR_SYNC   = 3;
   localparam int HDR_X_SIGN = 4;
   localparam int HDR_Y_SIGN = 5;
   localparam int HDR_X_OVF  = 6;
   localparam int HDR_Y_OVF  = 7;

   localparam logic signed [8:0] DELTA_MAX = 9'sd127;
   localparam logic signed [8:0] DELTA_MIN = -9'sd127;

   typedef struct packed {
      logic       done;
      logic [7:0] header;
      logic [7:0] dx;
      logic [7:0] dy;
   } frame_evt_type;

   // 9-bit two's complement delta; overflow saturates to +/-127
   function automatic logic signed [8:0] decode_delta(input logic [7:0] raw,
                                                      input logic sign,
                                                      input logic ovf);
      logic signed [8:0] d;
      d = $signed({sign, raw});
      if (ovf) begin
         d = sign ? DELTA_MIN : DELTA_MAX;
      end
      return d;
   endfunction

endpackage

// File: hw/rtl/ps2mt_req_if.sv
// ----------------------------------------------------------------------------
// ps2mt_req_if
// Request channel: mouse data byte or consume-click request.
// ----------------------------------------------------------------------------
interface ps2mt_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [7:0] data_byte;

   modport source (output valid, output req_type, output data_byte, input ready);
   modport sink   (input valid, input req_type, input data_byte, output ready);
endinterface

// File: hw/rtl/ps2mt_rsp_if.sv
// ----------------------------------------------------------------------------
// ps2mt_rsp_if
// Response channel: cursor state and consumed click.
// ----------------------------------------------------------------------------
interface ps2mt_rsp_if #(
   parameter int COORD_BITS = ps2mt_pkg::COORD_BITS_DEF
);
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] cursor_x;
   logic [COORD_BITS-1:0] cursor_y;
   logic                  left_down;
   logic                  right_down;
   logic                  middle_down;
   logic                  packet_done;
   logic                  click_taken;
   logic [COORD_BITS-1:0] taken_click_x;
   logic [COORD_BITS-1:0] taken_click_y;

   modport source (output valid, output cursor_x, output cursor_y, output left_down,
                   output right_down, output middle_down, output packet_done,
                   output click_taken, output taken_click_x, output taken_click_y,
                   input ready);
   modport sink   (input valid, input cursor_x, input cursor_y, input left_down,
                   input right_down, input middle_down, input packet_done,
                   input click_taken, input taken_click_x, input taken_click_y,
                   output ready);
endinterface

// File: hw/rtl/ps2mt_frame.sv
// ----------------------------------------------------------------------------
// ps2mt_frame
// Packet framing: tracks byte phase, holds header and dx bytes.
// ----------------------------------------------------------------------------
module ps2mt_frame (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic                     req_type,
   input  logic [7:0]               data_byte,
   output ps2mt_pkg::frame_evt_type evt
);

   localparam logic [1:0] PHASE_HEADER = 2'd0;
   localparam logic [1:0] PHASE_DX     = 2'd1;
   localparam logic [1:0] PHASE_DY     = 2'd2;

   logic [1:0] phase_ff, phase_in;
   logic [7:0] header_ff, header_in;
   logic [7:0] dx_ff, dx_in;
   logic       done;

   always_comb begin
      phase_in  = phase_ff;
      header_in = header_ff;
      dx_in     = dx_ff;
      done      = 1'b0;
      if (accept && req_type == ps2mt_pkg::REQ_DATA) begin
         case (phase_ff)
            PHASE_DX: begin
               dx_in    = data_byte;
               phase_in = PHASE_DY;
            end
            PHASE_DY: begin
               phase_in = PHASE_HEADER;
               done     = 1'b1;
            end
            default: begin
               // resync: a first byte without the always-one bit is dropped
               if (data_byte[ps2mt_pkg::HDR_SYNC]) begin
                  header_in = data_byte;
                  phase_in  = PHASE_DX;
               end else begin
                  phase_in = PHASE_HEADER;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PHASE_HEADER;
         header_ff <= '0;
         dx_ff     <= '0;
      end else begin
         phase_ff  <= phase_in;
         header_ff <= header_in;
         dx_ff     <= dx_in;
      end
   end

   assign evt.done   = done;
   assign evt.header = header_ff;
   assign evt.dx     = dx_ff;
   assign evt.dy     = data_byte;

endmodule

// File: hw/rtl/ps2mt_track.sv
// ----------------------------------------------------------------------------
// ps2mt_track
// Cursor position, button state, click latch and screen bound registers.
// ----------------------------------------------------------------------------
module ps2mt_track #(
   parameter int COORD_BITS = ps2mt_pkg::COORD_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [ps2mt_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [ps2mt_pkg::SIZE_BITS-1:0]        csr_wdata,
   input  logic                                   accept,
   input  logic                                   req_type,
   input  ps2mt_pkg::frame_evt_type               evt,
   output logic [COORD_BITS-1:0]                  cursor_x,
   output logic [COORD_BITS-1:0]                  cursor_y,
   output logic [2:0]                             buttons,
   output logic                                   click_taken,
   output logic [COORD_BITS-1:0]                  taken_click_x,
   output logic [COORD_BITS-1:0]                  taken_click_y
);

   localparam int CALC_W = COORD_BITS + 2;
   localparam int LIM_W  = (COORD_BITS > ps2mt_pkg::SIZE_BITS) ?
                           COORD_BITS : ps2mt_pkg::SIZE_BITS;
   localparam logic [COORD_BITS-1:0] CoordMask = '1;
   localparam logic [COORD_BITS-1:0] ResetX = COORD_BITS'(ps2mt_pkg::RESET_X);
   localparam logic [COORD_BITS-1:0] ResetY = COORD_BITS'(ps2mt_pkg::RESET_Y);

   function automatic logic [COORD_BITS-1:0] bound_limit(
         input logic [ps2mt_pkg::SIZE_BITS-1:0] size);
      logic [LIM_W-1:0] m1;
      // zero size acts as one
      m1 = (size == '0) ? '0 : LIM_W'(size - 1'b1);
      if (m1 > LIM_W'(CoordMask)) begin
         m1 = LIM_W'(CoordMask);
      end
      return COORD_BITS'(m1);
   endfunction

   function automatic logic [COORD_BITS-1:0] clamp_coord(
         input logic signed [CALC_W-1:0] v,
         input logic [COORD_BITS-1:0]    lim);
      if (v < 0) begin
         return '0;
      end else if (v[CALC_W-2:0] > {1'b0, lim}) begin
         return lim;
      end else begin
         return v[COORD_BITS-1:0];
      end
   endfunction

   logic [ps2mt_pkg::SIZE_BITS-1:0] width_ff, height_ff;
   logic [COORD_BITS-1:0] pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic [2:0]            btn_ff, btn_in;
   logic                  pend_ff, pend_in;
   logic [COORD_BITS-1:0] col_ff, col_in, row_ff, row_in;

   logic signed [8:0]        dx, dy;
   logic signed [CALC_W-1:0] nx, ny;
   logic [COORD_BITS-1:0]    cx, cy;

   always_comb begin
      dx = ps2mt_pkg::decode_delta(evt.dx, evt.header[ps2mt_pkg::HDR_X_SIGN],
                                   evt.header[ps2mt_pkg::HDR_X_OVF]);
      dy = ps2mt_pkg::decode_delta(evt.dy, evt.header[ps2mt_pkg::HDR_Y_SIGN],
                                   evt.header[ps2mt_pkg::HDR_Y_OVF]);
      nx = $signed({2'b00, pos_x_ff}) + CALC_W'(dx);
      ny = $signed({2'b00, pos_y_ff}) - CALC_W'(dy);
      cx = clamp_coord(nx, bound_limit(width_ff));
      cy = clamp_coord(ny, bound_limit(height_ff));
   end

   always_comb begin
      pos_x_in      = pos_x_ff;
      pos_y_in      = pos_y_ff;
      btn_in        = btn_ff;
      pend_in       = pend_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      click_taken   = 1'b0;
      taken_click_x = '0;
      taken_click_y = '0;
      if (accept) begin
         if (req_type == ps2mt_pkg::REQ_CONSUME) begin
            if (pend_ff) begin
               click_taken   = 1'b1;
               taken_click_x = col_ff;
               taken_click_y = row_ff;
               pend_in       = 1'b0;
            end
         end else if (evt.done) begin
            pos_x_in = cx;
            pos_y_in = cy;
            // left press edge latches the new position
            if (evt.header[ps2mt_pkg::HDR_LEFT] && !btn_ff[0]) begin
               pend_in = 1'b1;
               col_in  = cx;
               row_in  = cy;
            end
            btn_in = evt.header[2:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= ps2mt_pkg::RESET_WIDTH;
         height_ff <= ps2mt_pkg::RESET_HEIGHT;
         pos_x_ff  <= ResetX;
         pos_y_ff  <= ResetY;
         btn_ff    <= '0;
         pend_ff   <= 1'b0;
         col_ff    <= ResetX;
         row_ff    <= ResetY;
      end else begin
         if (csr_we && csr_index == ps2mt_pkg::REG_SCREEN_WIDTH) begin
            width_ff <= csr_wdata;
         end
         if (csr_we && csr_index == ps2mt_pkg::REG_SCREEN_HEIGHT) begin
            height_ff <= csr_wdata;
         end
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
         btn_ff   <= btn_in;
         pend_ff  <= pend_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
      end
   end

   assign cursor_x = pos_x_in;
   assign cursor_y = pos_y_in;
   assign buttons  = btn_in;

endmodule

// File: hw/rtl/ps2mt_skid.sv
// ----------------------------------------------------------------------------
// ps2mt_skid
// Two-entry output register with skid slot; ready is registered.
// ----------------------------------------------------------------------------
module ps2mt_skid #(
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [DATA_W-1:0] in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [DATA_W-1:0] out_data
);

   logic              main_valid_ff, main_valid_in;
   logic              skid_valid_ff, skid_valid_in;
   logic [DATA_W-1:0] main_data_ff, main_data_in;
   logic [DATA_W-1:0] skid_data_ff, skid_data_in;
   logic              taken, accept;

   assign in_ready = !skid_valid_ff;
   assign accept   = in_valid && in_ready;
   assign taken    = main_valid_ff && out_ready;

   always_comb begin
      main_valid_in = main_valid_ff;
      main_data_in  = main_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (taken) begin
            main_valid_in = 1'b1;
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (!main_valid_ff || taken) begin
            main_valid_in = 1'b1;
            main_data_in  = in_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = in_data;
         end
      end else if (taken) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;

endmodule

// File: hw/rtl/ps2_mouse_packet_tracker_top.sv
// ----------------------------------------------------------------------------
// ps2_mouse_packet_tracker_top
// Responses are registered; state updates in a single pass.
// One request per cycle while the skid slot is empty.
// A two-entry output stage keeps accepting while one response waits.
// Reset (synchronous): cursor 960/540, bounds 1920x1080, no click pending.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_tracker_top #(
   parameter int COORD_BITS = ps2mt_pkg::COORD_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [ps2mt_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [ps2mt_pkg::SIZE_BITS-1:0]      csr_wdata,
   ps2mt_req_if.sink                            req_if,
   ps2mt_rsp_if.source                          rsp_if
);

   localparam int RSP_W = 4 * COORD_BITS + 5;

   logic                     accept;
   ps2mt_pkg::frame_evt_type evt;
   logic [COORD_BITS-1:0]    cursor_x, cursor_y, taken_x, taken_y;
   logic [2:0]               buttons;
   logic                     taken;
   logic [RSP_W-1:0]         rsp_in, rsp_out;

   assign accept = req_if.valid && req_if.ready;

   ps2mt_frame u_frame (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_type  (req_if.req_type),
      .data_byte (req_if.data_byte),
      .evt       (evt)
   );

   ps2mt_track #(
      .COORD_BITS (COORD_BITS)
   ) u_track (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .accept        (accept),
      .req_type      (req_if.req_type),
      .evt           (evt),
      .cursor_x      (cursor_x),
      .cursor_y      (cursor_y),
      .buttons       (buttons),
      .click_taken   (taken),
      .taken_click_x (taken_x),
      .taken_click_y (taken_y)
   );

   assign rsp_in = {cursor_x, cursor_y, buttons, evt.done, taken, taken_x, taken_y};

   ps2mt_skid #(
      .DATA_W (RSP_W)
   ) u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_if.valid),
      .in_ready  (req_if.ready),
      .in_data   (rsp_in),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .out_data  (rsp_out)
   );

   assign {rsp_if.cursor_x, rsp_if.cursor_y,
           rsp_if.middle_down, rsp_if.right_down, rsp_if.left_down,
           rsp_if.packet_done, rsp_if.click_taken,
           rsp_if.taken_click_x, rsp_if.taken_click_y} = rsp_out;

endmodule

// File: hw/rtl/ps2mt_checker.sv
// ----------------------------------------------------------------------------
// ps2mt_checker
// Port-level checks of the PS/2 mouse packet tracker, bound to the top.
// ----------------------------------------------------------------------------
`include "ps2_mouse_packet_tracker_top_assert.svh"

module ps2mt_checker #(
   parameter int COORD_BITS = ps2mt_pkg::COORD_BITS_DEF
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic                  packet_done,
   input logic                  click_taken,
   input logic [COORD_BITS-1:0] taken_click_x,
   input logic [COORD_BITS-1:0] taken_click_y
);

   `PS2MT_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "response valid after reset")
   `PS2MT_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "response dropped")
   `PS2MT_ASSERT(a_done_xor_take, rsp_valid |-> !(packet_done && click_taken), "done with take")
   `PS2MT_ASSERT(a_untaken_zero, rsp_valid && !click_taken |-> taken_click_x == '0 && taken_click_y == '0, "click fields set")
   `PS2MT_ASSERT(a_stall_full, !req_ready |-> rsp_valid, "stalled with empty output")

endmodule

bind ps2_mouse_packet_tracker_top ps2mt_checker #(
   .COORD_BITS (COORD_BITS)
) u_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_if.ready),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .packet_done   (rsp_if.packet_done),
   .click_taken   (rsp_if.click_taken),
   .taken_click_x (rsp_if.taken_click_x),
   .taken_click_y (rsp_if.taken_click_y)
);
